@@ hw/rtl/sha1bs_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the sha-1 byte stream hasher
// no dependencies; used by sha1bs_round and sha1_byte_stream_hasher_core

package sha1bs_pkg;

    typedef logic [31:0] t_word;

    // working variables a..e of one compression
    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
    } t_vars;

    localparam int NUM_WORDS   = 16;
    localparam int NUM_HASH    = 5;
    localparam int NUM_ROUNDS  = 80;

    // initial chaining words h0..h4
    localparam t_word H_INIT [NUM_HASH] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    // round constants, one per group of twenty rounds
    localparam t_word K_TABLE [4] = '{
        32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
    };

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [2:0] LAST_IDX = 3'd4;
    localparam logic [6:0] LAST_ROUND = 7'(NUM_ROUNDS - 1);

endpackage

@@ hw/rtl/sha1bs_round.sv @@
`timescale 1ns / 1ps
// one sha-1 compression round: round function, constant select and the five-way add
// depends on sha1bs_pkg

module sha1bs_round (
    input  sha1bs_pkg::t_vars  i_vars,
    input  sha1bs_pkg::t_word  i_wt,
    input  logic [6:0]         i_round,
    output sha1bs_pkg::t_vars  o_vars
);
    import sha1bs_pkg::*;

    logic [1:0] phase;
    t_word      f;
    t_word      t;

    always_comb begin
        if (i_round < 7'd20) begin
            phase = 2'd0;
        end else if (i_round < 7'd40) begin
            phase = 2'd1;
        end else if (i_round < 7'd60) begin
            phase = 2'd2;
        end else begin
            phase = 2'd3;
        end
    end

    always_comb begin
        case (phase)
            2'd0:    f = (i_vars.b & i_vars.c) | (~i_vars.b & i_vars.d);
            2'd2:    f = (i_vars.b & i_vars.c) | (i_vars.b & i_vars.d)
                         | (i_vars.c & i_vars.d);
            default: f = i_vars.b ^ i_vars.c ^ i_vars.d;
        endcase
    end

    assign t = {i_vars.a[26:0], i_vars.a[31:27]} + f + i_vars.e + K_TABLE[phase] + i_wt;

    assign o_vars.a = t;
    assign o_vars.b = i_vars.a;
    assign o_vars.c = {i_vars.b[1:0], i_vars.b[31:2]};
    assign o_vars.d = i_vars.c;
    assign o_vars.e = i_vars.d;

endmodule

@@ hw/rtl/sha1_byte_stream_hasher_core.sv @@
`timescale 1ns / 1ps
// sha-1 byte stream hasher, top level: byte packing, padding, round sequencer, digest output
// depends on sha1bs_pkg and sha1bs_round
//
// input channel: one transfer per item (i_msg_byte, i_has_byte, i_end_of_message),
//   taken when i_in_valid is high and o_in_stall is low
// output channel: five transfers per message, digest words h0..h4 in order,
//   o_last_word marks h4; the receiver holds them back with i_out_stall
// input rate: message bytes are taken one per cycle while the block is idle; the byte that
//   fills a 64-byte block starts a compression of 80 rounds followed by the chaining add,
//   all rounds running through the single round unit
// end of message: padding bytes are generated one per cycle up to the block end
//   (one or two blocks), each block compressed as above, then the five digest words
//   follow one per cycle while i_out_stall is low
// the input is stalled during compression, padding and digest output
// a stalled output word stays put; after h4 is taken the block reloads the initial
//   chaining words, clears the bit count and takes the next message at byte position 0
// reset (synchronous, active low) returns the block to the idle state with the
//   initial chaining words loaded and nothing pending

module sha1_byte_stream_hasher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha1bs_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    // control state
    logic [2:0]  r_state, n_state;
    logic [5:0]  r_pos, n_pos;          // byte position in the current block
    logic [60:0] r_cnt, n_cnt;          // message byte count, bit count is cnt * 8
    logic [6:0]  r_round, n_round;
    logic        r_pad, n_pad;          // message ended, padding in progress
    logic        r_first, n_first;      // next pad byte is the 0x80 marker
    logic        r_len_blk, n_len_blk;  // current block carries the length
    logic        r_final, n_final;      // compression running on the last block
    logic [2:0]  r_out_idx, n_out_idx;

    // datapath
    t_word       r_h [NUM_HASH];
    t_word       n_h [NUM_HASH];
    t_vars       r_vars, n_vars;
    t_word       r_w [NUM_WORDS];       // message schedule window
    t_word       n_w [NUM_WORDS];
    logic [23:0] r_acc, n_acc;          // bytes of the word being packed

    t_vars       round_vars;
    t_word       sched_mix;
    t_word       sched_word;
    logic [63:0] len_bits;
    logic [7:0]  pad_byte;
    logic        put_en;
    logic [7:0]  put_val;
    logic        in_xfer;
    logic        out_xfer;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = o_out_valid && !i_out_stall;

    sha1bs_round u_round (
        .i_vars  (r_vars),
        .i_wt    (r_w[0]),
        .i_round (r_round),
        .o_vars  (round_vars)
    );

    // next schedule word from fixed taps of the window
    assign sched_mix  = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign sched_word = {sched_mix[30:0], sched_mix[31]};

    assign len_bits = {r_cnt, 3'b000};

    // marker, zero fill, then the big-endian bit length in the last eight bytes
    always_comb begin
        if (r_first) begin
            pad_byte = PAD_MARK;
        end else if (r_len_blk && (r_pos >= LEN_POS)) begin
            pad_byte = len_bits[{~r_pos[2:0], 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_cnt     = r_cnt;
        n_round   = r_round;
        n_pad     = r_pad;
        n_first   = r_first;
        n_len_blk = r_len_blk;
        n_final   = r_final;
        n_out_idx = r_out_idx;
        n_h       = r_h;
        n_vars    = r_vars;
        n_w       = r_w;
        n_acc     = r_acc;
        put_en    = 1'b0;
        put_val   = pad_byte;

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (i_has_byte) begin
                        put_en  = 1'b1;
                        put_val = i_msg_byte;
                        n_cnt   = r_cnt + 61'd1;
                    end
                    if (i_end_of_message) begin
                        n_pad   = 1'b1;
                        n_first = 1'b1;
                    end
                    if (i_has_byte && (r_pos == LAST_POS)) begin
                        n_state = ST_ROUND;
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                put_en  = 1'b1;
                n_first = 1'b0;
                if (r_first && (r_pos < LEN_POS)) begin
                    n_len_blk = 1'b1;
                end
                if (r_pos == LAST_POS) begin
                    n_state = ST_ROUND;
                    if (r_len_blk) begin
                        n_final = 1'b1;
                    end else begin
                        // marker landed too late, length goes in the next block
                        n_len_blk = 1'b1;
                    end
                end
            end
            ST_ROUND: begin
                n_vars = round_vars;
                for (int i = 0; i < NUM_WORDS - 1; i++) begin
                    n_w[i] = r_w[i + 1];
                end
                n_w[NUM_WORDS - 1] = sched_word;
                if (r_round == LAST_ROUND) begin
                    n_round = 7'd0;
                    n_state = ST_ADD;
                end else begin
                    n_round = r_round + 7'd1;
                end
            end
            ST_ADD: begin
                n_h[0] = r_h[0] + r_vars.a;
                n_h[1] = r_h[1] + r_vars.b;
                n_h[2] = r_h[2] + r_vars.c;
                n_h[3] = r_h[3] + r_vars.d;
                n_h[4] = r_h[4] + r_vars.e;
                if (r_final) begin
                    n_state = ST_OUT;
                end else if (r_pad) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_xfer) begin
                    if (r_out_idx == LAST_IDX) begin
                        // digest delivered, start a fresh message
                        n_state   = ST_IDLE;
                        n_out_idx = 3'd0;
                        n_cnt     = '0;
                        n_pad     = 1'b0;
                        n_first   = 1'b0;
                        n_len_blk = 1'b0;
                        n_final   = 1'b0;
                        for (int i = 0; i < NUM_HASH; i++) begin
                            n_h[i] = H_INIT[i];
                        end
                    end else begin
                        n_out_idx = r_out_idx + 3'd1;
                        for (int i = 0; i < NUM_HASH - 1; i++) begin
                            n_h[i] = r_h[i + 1];
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // byte packing, big-endian, a full word enters the schedule window
        if (put_en) begin
            n_pos = r_pos + 6'd1;
            if (r_pos[1:0] == 2'd3) begin
                for (int i = 0; i < NUM_WORDS - 1; i++) begin
                    n_w[i] = r_w[i + 1];
                end
                n_w[NUM_WORDS - 1] = {r_acc, put_val};
            end else begin
                n_acc = {r_acc[15:0], put_val};
            end
            if (r_pos == LAST_POS) begin
                n_vars = {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pos     <= '0;
            r_cnt     <= '0;
            r_round   <= '0;
            r_pad     <= 1'b0;
            r_first   <= 1'b0;
            r_len_blk <= 1'b0;
            r_final   <= 1'b0;
            r_out_idx <= '0;
            r_vars    <= '0;
            for (int i = 0; i < NUM_HASH; i++) begin
                r_h[i] <= H_INIT[i];
            end
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_cnt     <= n_cnt;
            r_round   <= n_round;
            r_pad     <= n_pad;
            r_first   <= n_first;
            r_len_blk <= n_len_blk;
            r_final   <= n_final;
            r_out_idx <= n_out_idx;
            r_vars    <= n_vars;
            r_h       <= n_h;
        end
    end

    // schedule window and packing word carry no reset
    always_ff @(posedge i_clk) begin
        r_w   <= n_w;
        r_acc <= n_acc;
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = (r_state == ST_OUT);
    assign o_digest_word = r_h[0];
    assign o_word_index  = r_out_idx;
    assign o_last_word   = (r_out_idx == LAST_IDX);

`ifndef SYNTH
    // no input transfer while a digest is being delivered
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open during digest output");

    // digest output only on a block boundary
    a_out_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pos == 6'd0) && (o_word_index <= LAST_IDX))
        else $error("digest output off a block boundary");

    // round counter only moves during compression
    a_round_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_ROUND) |-> (r_round == 7'd0))
        else $error("round counter active outside compression");

    // after the last word the chaining state is back at its start
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_last_word) |=> (r_h[0] == H_INIT[0]) && (r_cnt == '0)
            && !r_pad && !o_in_stall)
        else $error("message state not cleared after digest");

    // a length block is never compressed without the marker placed
    a_final_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_final |-> (r_pad && r_len_blk && !r_first))
        else $error("final block flagged out of order");
`endif

endmodule
